/* rtl/core/tpd_pkg.sv */
// Package of the touch report decoder: result codes, the report record passed
// from the front part to the back part, and the shared constants.
// No dependencies.
package tpd_pkg;

    localparam int unsigned TPD_REPORT_LEN   = 8;
    localparam int unsigned TPD_STORED_BYTES = TPD_REPORT_LEN - 1;
    localparam int unsigned TPD_POS_W        = $clog2(TPD_REPORT_LEN);
    localparam int unsigned TPD_QUEUE_DEPTH  = 2;

    localparam logic [7:0] TPD_ID_RESET  = 8'h52;
    localparam logic [7:0] TPD_KEY_BYTE  = 8'hff;

    // Result status; the front part only ever issues the first three, the back
    // part turns a valid touch into no coordinates when every held value is zero.
    typedef enum logic [1:0] {
        ST_TOUCH    = 2'd0,
        ST_BAD_ID   = 2'd1,
        ST_BAD_SUM  = 2'd2,
        ST_NO_COORD = 2'd3
    } t_status;

    typedef struct packed {
        t_status    cls;
        logic [7:0] xhyh;
        logic [7:0] xl;
        logic [7:0] yl;
        logic [7:0] dh;
        logic [7:0] dxl;
        logic [7:0] dyl;
    } t_report;

endpackage

/* rtl/core/touch_packet_decoder.sv */
// Top level of the touch report decoder: front part, report queue, back part.
// Depends on tpd_pkg, tpd_front, tpd_queue and tpd_back.
//
//  Channel     | Direction | Contents
//  ------------+-----------+---------------------------------------------------
//  s_axis      | in        | one report byte per request, start flag in tuser
//  m_axis      | out       | one decoded result per eight-byte report
//  i_cfg_wr_*  | in        | write of the expected identifier byte
//
// One byte is taken per clock while the report queue has room. The eighth byte of
// a report is written into the report queue and then loaded into the back part's
// output register, where its result is presented. The queue holds QueueDepth
// reports; the input stalls whenever QueueDepth finished reports wait in the
// queue behind the output register.
// Reset is synchronous and active low; it clears the byte count, the running
// checksum, the held coordinates and the queue, and restores the identifier
// to its default.
module touch_packet_decoder #(
    parameter int unsigned QueueDepth = tpd_pkg::TPD_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: expected identifier byte.
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    // Input bytes.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] packet_start
    // Decoded results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] key_code, [19:8] first_x,
                                        // [31:20] first_y, [47:32] second_x,
                                        // [63:48] second_y
    output logic [2:0]  m_axis_tuser    // [1:0] status, [2] key_frame
);
    import tpd_pkg::*;

    logic        w_push;
    t_report     w_front_report;
    logic        w_q_ready;
    logic        w_q_valid;
    t_report     w_q_report;
    logic        w_pop;
    t_status     w_status;
    logic        w_key_frame;
    logic [7:0]  w_key_code;
    logic [11:0] w_first_x;
    logic [11:0] w_first_y;
    logic [15:0] w_second_x;
    logic [15:0] w_second_y;

    // The front part collects bytes and classifies each finished report; it
    // only waits when the queue is full.
    tpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .i_byte        (s_axis_tdata),
        .i_start       (s_axis_tuser[0]),
        .i_q_ready     (w_q_ready),
        .o_ready       (s_axis_tready),
        .o_push        (w_push),
        .o_report      (w_front_report)
    );

    tpd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_report (w_front_report),
        .i_pop    (w_pop),
        .o_ready  (w_q_ready),
        .o_valid  (w_q_valid),
        .o_report (w_q_report)
    );

    // The back part applies each report to the held coordinates in order and
    // loads its output register whenever that register is empty or draining.
    tpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_report    (w_q_report),
        .o_pop       (w_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (w_status),
        .o_key_frame (w_key_frame),
        .o_key_code  (w_key_code),
        .o_first_x   (w_first_x),
        .o_first_y   (w_first_y),
        .o_second_x  (w_second_x),
        .o_second_y  (w_second_y)
    );

    assign m_axis_tdata = {w_second_y, w_second_x, w_first_y, w_first_x, w_key_code};
    assign m_axis_tuser = {w_key_frame, w_status};

    // A key frame is only ever reported for a report that passed both checks.
    a_key_frame_checked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |->
        ((m_axis_tuser[1:0] == ST_TOUCH) || (m_axis_tuser[1:0] == ST_NO_COORD)))
        else $error("key frame reported for a rejected report");

    // Without a key frame there is no key code.
    a_key_code_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("key code set outside a key frame");

    // A valid touch always carries at least one non-zero held coordinate.
    a_touch_has_coords : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[1:0] == ST_TOUCH)) |->
        (m_axis_tdata[63:8] != '0))
        else $error("valid touch reported with all coordinates zero");

    // A report leaving the queue is in the output register on the next cycle.
    a_pop_loads_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> m_axis_tvalid)
        else $error("report popped but no result presented");

endmodule

/* rtl/core/tpd_front.sv */
// Front part of the touch report decoder: takes bytes, collects a report,
// checks identifier and checksum and hands a classified report to the queue.
// Depends on tpd_pkg.
module tpd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [7:0]      i_cfg_wr_data,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_start,
    input  logic            i_q_ready,
    output logic            o_ready,
    output logic            o_push,
    output tpd_pkg::t_report o_report
);
    import tpd_pkg::*;

    localparam logic [TPD_POS_W-1:0] LastPos = TPD_POS_W'(TPD_REPORT_LEN - 1);

    logic [7:0]           r_expected_id;
    logic [TPD_POS_W-1:0] r_pos;
    logic [TPD_POS_W-1:0] n_pos;
    logic [7:0]           r_sum;
    logic [7:0]           n_sum;
    logic [7:0]           r_bytes [0:TPD_STORED_BYTES-1];
    logic [TPD_POS_W-1:0] w_pos;
    logic                 w_accept;
    logic                 w_last;

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid && i_q_ready;
    // A start flag restarts the count before the byte is placed.
    assign w_pos    = i_start ? '0 : r_pos;
    assign w_last   = (w_pos == LastPos);
    assign o_push   = w_accept && w_last;

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (w_accept) begin
            if (w_last) begin
                n_pos = '0;
            end else begin
                n_pos = w_pos + 1'b1;
                n_sum = (w_pos == '0) ? i_byte : r_sum + i_byte;
            end
        end
    end

    always_comb begin
        o_report.xhyh = r_bytes[1];
        o_report.xl   = r_bytes[2];
        o_report.yl   = r_bytes[3];
        o_report.dh   = r_bytes[4];
        o_report.dxl  = r_bytes[5];
        o_report.dyl  = r_bytes[6];
        if (r_bytes[0] != r_expected_id) begin
            o_report.cls = ST_BAD_ID;
        end else if ((8'd0 - r_sum) != i_byte) begin
            o_report.cls = ST_BAD_SUM;
        end else begin
            o_report.cls = ST_TOUCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= TPD_ID_RESET;
            r_pos         <= '0;
            r_sum         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_expected_id <= i_cfg_wr_data;
            end
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_last) begin
            r_bytes[w_pos] <= i_byte;
        end
    end

endmodule

/* rtl/core/tpd_queue.sv */
// Short report queue between the front and back parts of the decoder.
// Depends on tpd_pkg.
module tpd_queue #(
    parameter int unsigned Depth = tpd_pkg::TPD_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tpd_pkg::t_report i_report,
    input  logic             i_pop,
    output logic             o_ready,
    output logic             o_valid,
    output tpd_pkg::t_report o_report
);
    import tpd_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastSlot = PtrW'(Depth - 1);

    t_report         r_mem [0:Depth-1];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            w_push;
    logic            w_pop;

    assign o_ready  = (r_count != CntW'(Depth));
    assign o_valid  = (r_count != '0);
    assign o_report = r_mem[r_rd_ptr];
    assign w_push   = i_push && o_ready;
    assign w_pop    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LastSlot) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastSlot) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_report;
        end
    end

endmodule

/* rtl/core/tpd_back.sv */
// Back part of the touch report decoder: decodes a classified report, keeps
// the held coordinates and drives the registered result.
// Depends on tpd_pkg.
module tpd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tpd_pkg::t_report i_report,
    output logic             o_pop,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output tpd_pkg::t_status o_status,
    output logic             o_key_frame,
    output logic [7:0]       o_key_code,
    output logic [11:0]      o_first_x,
    output logic [11:0]      o_first_y,
    output logic [15:0]      o_second_x,
    output logic [15:0]      o_second_y
);
    import tpd_pkg::*;

    logic        r_out_valid;
    t_status     r_status;
    logic        r_key_frame;
    logic [7:0]  r_key_code;
    logic [11:0] r_fx;
    logic [11:0] r_fy;
    logic [15:0] r_sx;
    logic [15:0] r_sy;

    t_status     n_status;
    logic        n_key_frame;
    logic [7:0]  n_key_code;
    logic [11:0] n_fx;
    logic [11:0] n_fy;
    logic [15:0] n_sx;
    logic [15:0] n_sy;

    logic        w_is_key;
    logic        w_has_second;
    logic [11:0] w_dx;
    logic [11:0] w_dy;

    assign o_pop = i_valid && (!r_out_valid || i_out_ready);

    assign w_is_key = (i_report.xhyh == TPD_KEY_BYTE) && (i_report.xl == TPD_KEY_BYTE)
                   && (i_report.yl == TPD_KEY_BYTE) && (i_report.dh == TPD_KEY_BYTE)
                   && (i_report.dyl == TPD_KEY_BYTE);
    assign w_has_second = (i_report.dh != 8'd0) || (i_report.dxl != 8'd0)
                       || (i_report.dyl != 8'd0);
    assign w_dx = {i_report.dh[7:4], i_report.dxl};
    assign w_dy = {i_report.dh[3:0], i_report.dyl};

    always_comb begin
        n_fx        = r_fx;
        n_fy        = r_fy;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_key_frame = 1'b0;
        n_key_code  = 8'd0;
        n_status    = i_report.cls;
        if (i_report.cls == ST_TOUCH) begin
            if (w_is_key) begin
                n_key_frame = 1'b1;
                n_key_code  = i_report.dxl;
            end else begin
                n_fx = {i_report.xhyh[7:4], i_report.xl};
                n_fy = {i_report.xhyh[3:0], i_report.yl};
                if (w_has_second) begin
                    // Deltas are signed 12-bit values, sign-extended to 16 bits.
                    n_sx = {4'd0, n_fx} + {{4{w_dx[11]}}, w_dx};
                    n_sy = {4'd0, n_fy} + {{4{w_dy[11]}}, w_dy};
                end
            end
            if ((n_fx == '0) && (n_fy == '0) && (n_sx == '0) && (n_sy == '0)) begin
                n_status = ST_NO_COORD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fx        <= '0;
            r_fy        <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_fx        <= n_fx;
                r_fy        <= n_fy;
                r_sx        <= n_sx;
                r_sy        <= n_sy;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status    <= n_status;
            r_key_frame <= n_key_frame;
            r_key_code  <= n_key_code;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_key_frame = r_key_frame;
    assign o_key_code  = r_key_code;
    assign o_first_x   = r_fx;
    assign o_first_y   = r_fy;
    assign o_second_x  = r_sx;
    assign o_second_y  = r_sy;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the touch report decoder: streams report bytes in bursts,
// predicts every decoded result in the bench and checks the output stream against it.
// Depends on tpd_pkg and touch_packet_decoder.
module testbench;
    import tpd_pkg::*;

    // Input bytes queued per phase of random traffic.
    localparam int unsigned PhaseBytes   = 200;
    // Length of the deliberate output hold-off, long enough to fill the report queue.
    localparam int unsigned LongHold     = 400;
    // Quiet cycles allowed after the last expected result.
    localparam int unsigned SettleCycles = 16;
    localparam int unsigned CycleLimit   = 200000;
    localparam int unsigned ReportLimit  = 10;

    // One decoded result, field for field as the output bus carries it.
    typedef struct packed {
        t_status     status;
        logic        key_frame;
        logic [7:0]  key_code;
        logic [11:0] first_x;
        logic [11:0] first_y;
        logic [15:0] second_x;
        logic [15:0] second_y;
    } t_decode;

    // One report byte waiting to be offered, with its start-of-report flag.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_report_byte;

    // Patterns the result receiver cycles through when it is not in a long hold-off.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } t_rx_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser  = 1'b0;    // [0] packet_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;            // [7:0] key_code, [19:8] first_x,
                                          // [31:20] first_y, [47:32] second_x,
                                          // [63:48] second_y
    logic [2:0]  m_axis_tuser;            // [1:0] status, [2] key_frame

    touch_packet_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // The identifier currently programmed. It only changes while the block is idle,
    // so the generator and the decoder copy below may both read it.
    logic [7:0]   id_setting = TPD_ID_RESET;

    // Bench copy of the decoder state.
    logic [2:0]   rep_pos = '0;
    logic [7:0]   rep_bytes [0:TPD_STORED_BYTES-1];
    logic [7:0]   rep_sum = '0;
    logic [11:0]  held_fx = '0;
    logic [11:0]  held_fy = '0;
    logic [15:0]  held_sx = '0;
    logic [15:0]  held_sy = '0;

    t_decode      decodes_q [$];      // results predicted but not yet seen
    t_report_byte byte_fifo [$];      // bytes waiting to be offered
    int unsigned  bytes_queued = 0;
    int unsigned  fail_count   = 0;
    int unsigned  cycle_count  = 0;
    logic         stream_aligned = 1'b1;  // generator knows the byte count is at zero

    // Decodes one accepted byte exactly as the block should, and on the eighth byte
    // of a report appends the result it must give.
    task automatic decode_report_byte(input logic [7:0] data, input logic start);
        t_decode     res;
        logic [7:0]  want_sum;
        logic [11:0] dx;
        logic [11:0] dy;
        // A start flag forces the byte to be taken as the first of a report.
        if (start)
            rep_pos = '0;
        if (rep_pos < TPD_STORED_BYTES) begin
            rep_bytes[rep_pos] = data;
            rep_sum = (rep_pos == 0) ? data : rep_sum + data;
            rep_pos = rep_pos + 3'd1;
        end else begin
            // Eighth byte: the count wraps, so the following byte starts a report.
            rep_pos       = '0;
            want_sum      = 8'h00 - rep_sum;
            res.key_frame = 1'b0;
            res.key_code  = '0;
            // A rejected report leaves every held coordinate untouched.
            if (rep_bytes[0] != id_setting) begin
                res.status = ST_BAD_ID;
            end else if (data != want_sum) begin
                res.status = ST_BAD_SUM;
            end else begin
                if (rep_bytes[1] == TPD_KEY_BYTE && rep_bytes[2] == TPD_KEY_BYTE &&
                    rep_bytes[3] == TPD_KEY_BYTE && rep_bytes[4] == TPD_KEY_BYTE &&
                    rep_bytes[6] == TPD_KEY_BYTE) begin
                    // Key frame: the coordinates are kept and dxl is the key code.
                    res.key_frame = 1'b1;
                    res.key_code  = rep_bytes[5];
                end else begin
                    held_fx = {rep_bytes[1][7:4], rep_bytes[2]};
                    held_fy = {rep_bytes[1][3:0], rep_bytes[3]};
                    // The second point only moves when one of its bytes is non-zero;
                    // its deltas are signed 12-bit and the sums wrap at 16 bits.
                    if ({rep_bytes[4], rep_bytes[5], rep_bytes[6]} != 24'd0) begin
                        dx      = {rep_bytes[4][7:4], rep_bytes[5]};
                        dy      = {rep_bytes[4][3:0], rep_bytes[6]};
                        held_sx = {4'd0, held_fx} + {{4{dx[11]}}, dx};
                        held_sy = {4'd0, held_fy} + {{4{dy[11]}}, dy};
                    end
                end
                // A key frame with nothing held still reports no coordinates.
                res.status = ({held_fx, held_fy, held_sx, held_sy} == '0) ?
                             ST_NO_COORD : ST_TOUCH;
            end
            res.first_x  = held_fx;
            res.first_y  = held_fy;
            res.second_x = held_sx;
            res.second_y = held_sy;
            decodes_q.push_back(res);
        end
    endtask

    function automatic string decode_text(input t_decode d);
        return $sformatf("status=%0d key=%0b/%02h first=(%03h,%03h) second=(%04h,%04h)",
                         d.status, d.key_frame, d.key_code, d.first_x, d.first_y,
                         d.second_x, d.second_y);
    endfunction

    // Byte values weighted towards the extremes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] data, input logic start);
        t_report_byte rb;
        rb.data  = data;
        rb.start = start;
        byte_fifo.push_back(rb);
        bytes_queued++;
    endtask

    // Queues a whole eight-byte report; the checksum is right unless sum_ok is low.
    task automatic push_report(input logic [7:0] id, xhyh, xl, yl, dh, dxl, dyl,
                               input logic sum_ok, input logic start);
        logic [7:0] sum;
        logic [7:0] tail;
        sum  = id + xhyh + xl + yl + dh + dxl + dyl;
        tail = 8'h00 - sum;
        if (!sum_ok)
            tail = tail ^ 8'($urandom_range(1, 255));
        push_byte(id, start);
        push_byte(xhyh, 1'b0);
        push_byte(xl, 1'b0);
        push_byte(yl, 1'b0);
        push_byte(dh, 1'b0);
        push_byte(dxl, 1'b0);
        push_byte(dyl, 1'b0);
        push_byte(tail, 1'b0);
    endtask

    // Mostly well-formed reports with random content, the rest rejected reports,
    // torn reports and stray bytes. A report only leans on the count wrapping
    // when the generator knows the stream is in step.
    task automatic push_random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        logic        start;
        stop_at = bytes_queued + count;
        while (bytes_queued < stop_at) begin
            pick  = $urandom_range(0, 99);
            start = stream_aligned ? ($urandom_range(0, 3) != 0) : 1'b1;
            if (pick < 30) begin
                push_report(id_setting, pick_byte(), pick_byte(), pick_byte(),
                            8'h00, 8'h00, 8'h00, 1'b1, start);
                stream_aligned = 1'b1;
            end else if (pick < 64) begin
                push_report(id_setting, pick_byte(), pick_byte(), pick_byte(),
                            pick_byte(), pick_byte(), pick_byte(), 1'b1, start);
                stream_aligned = 1'b1;
            end else if (pick < 72) begin
                push_report(id_setting, TPD_KEY_BYTE, TPD_KEY_BYTE, TPD_KEY_BYTE,
                            TPD_KEY_BYTE, 8'($urandom), TPD_KEY_BYTE, 1'b1, start);
                stream_aligned = 1'b1;
            end else if (pick < 80) begin
                push_report(id_setting ^ 8'($urandom_range(1, 255)), pick_byte(),
                            pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                            pick_byte(), 1'b1, start);
                stream_aligned = 1'b1;
            end else if (pick < 88) begin
                push_report(id_setting, pick_byte(), pick_byte(), pick_byte(),
                            pick_byte(), pick_byte(), pick_byte(), 1'b0, start);
                stream_aligned = 1'b1;
            end else if (pick < 94) begin
                // Torn report: the next one has to resynchronise.
                len = $urandom_range(1, 7);
                for (int unsigned k = 0; k < len; k++)
                    push_byte(k == 0 ? id_setting : pick_byte(), k == 0);
                stream_aligned = 1'b0;
            end else begin
                len = $urandom_range(1, 4);
                for (int unsigned k = 0; k < len; k++)
                    push_byte(8'($urandom), 1'($urandom));
                stream_aligned = 1'b0;
            end
        end
    endtask

    // Holds the sender back until every queued byte is taken and every predicted
    // result has arrived, then lets the pipeline settle.
    task automatic wait_drained();
        while (byte_fifo.size() != 0 || s_axis_tvalid || decodes_q.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_expected_id(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        id_setting     = value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Byte driver: offers the head of the queue in bursts of random length with
    // random gaps between them. An open request is never withdrawn.
    // ------------------------------------------------------------------
    logic        byte_taken = 1'b0;   // the head was accepted at the last rising edge
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin : drive_bytes
        logic offer;
        offer = 1'b0;
        if (byte_taken)
            void'(byte_fifo.pop_front());
        if (s_axis_tvalid && !byte_taken) begin
            offer = 1'b1;
        end else if (i_rst_n && byte_fifo.size() != 0) begin
            if (gap_left != 0) begin
                gap_left--;
            end else begin
                offer = 1'b1;
                if (burst_left != 0)
                    burst_left--;
                if (burst_left == 0) begin
                    // About a third of the bursts run straight into the next one.
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        s_axis_tvalid <= offer;
        if (offer) begin
            s_axis_tdata <= byte_fifo[0].data;
            s_axis_tuser <= byte_fifo[0].start;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: switches between stall patterns at random intervals, and
    // holds off entirely for a long stretch whenever the stimulus asks for it.
    // ------------------------------------------------------------------
    int unsigned hold_asks   = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left   = 0;
    int unsigned mode_left   = 0;
    int unsigned rx_tick     = 0;
    t_rx_mode    rx_mode     = RX_OPEN;

    always @(negedge i_clk) begin : drive_ready
        logic ready;
        ready = 1'b1;
        if (hold_served != hold_asks) begin
            hold_served++;
            hold_left = LongHold;
        end
        if (hold_left != 0) begin
            hold_left--;
            ready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:     ready = 1'b1;
                RX_COIN:     ready = 1'($urandom_range(0, 1));
                RX_MOSTLY:   ready = ($urandom_range(0, 4) != 0);
                RX_PERIODIC: ready = ((rx_tick % 7) < 3);
                default:     ready = 1'b1;
            endcase
        end
        m_axis_tready <= ready;
    end

    // ------------------------------------------------------------------
    // Scoreboard: at each rising edge the output request is checked first and the
    // input request decoded after it, so a result can never be matched against a
    // prediction made at the same edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_decode got;
        t_decode want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status    = t_status'(m_axis_tuser[1:0]);
            got.key_frame = m_axis_tuser[2];
            got.key_code  = m_axis_tdata[7:0];
            got.first_x   = m_axis_tdata[19:8];
            got.first_y   = m_axis_tdata[31:20];
            got.second_x  = m_axis_tdata[47:32];
            got.second_y  = m_axis_tdata[63:48];
            if (decodes_q.size() == 0) begin
                if (fail_count < ReportLimit)
                    $display("%0t: result with no report pending: %s", $time,
                             decode_text(got));
                fail_count++;
            end else begin
                want = decodes_q.pop_front();
                // The records are packed, so this covers every field, unknowns included.
                if (got !== want) begin
                    if (fail_count < ReportLimit)
                        $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                                 $time, decode_text(want), decode_text(got));
                    fail_count++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            decode_report_byte(s_axis_tdata, s_axis_tuser[0]);
            byte_taken <= 1'b1;
        end else begin
            byte_taken <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: a short directed opening and a random phase at the reset identifier,
    // then more phases, each under a new identifier written while the block is idle.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] id_plan [0:3];
        id_plan[0] = 8'h00;
        id_plan[1] = 8'hff;
        id_plan[2] = 8'($urandom_range(1, 254));
        id_plan[3] = TPD_ID_RESET;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Key frame straight after reset: nothing is held, so it carries the
        // no-coordinates status together with its key code.
        push_report(TPD_ID_RESET, 8'hff, 8'hff, 8'hff, 8'hff, 8'ha5, 8'hff, 1'b1, 1'b1);
        // A torn report, then a start flag resynchronises onto a report whose
        // identifier is wrong.
        push_byte(TPD_ID_RESET, 1'b1);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_report(8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 1'b1, 1'b1);
        // No start flag: the count has wrapped after the last result. First point at
        // the origin and both deltas at their most negative, so the sums wrap.
        push_report(TPD_ID_RESET, 8'h00, 8'h00, 8'h00, 8'h88, 8'h00, 8'h00, 1'b1, 1'b0);
        // Largest first point and largest positive deltas, but the checksum is off.
        push_report(TPD_ID_RESET, 8'hff, 8'hff, 8'hff, 8'h77, 8'hff, 8'hff, 1'b0, 1'b1);

        push_random_traffic(PhaseBytes);

        for (int p = 0; p < 4; p++) begin
            // Every phase boundary doubles as a pause until all results are in.
            wait_drained();
            write_expected_id(id_plan[p]);
            stream_aligned = 1'b0;
            push_random_traffic(PhaseBytes);
            if (p == 1) begin
                // Long output hold-off while bytes keep coming: the report queue
                // fills and the input has to stall.
                @(posedge i_clk);
                hold_asks++;
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
